// ===== hdl/baro_temp_pressure_compensation_assert.svh =====
// assertion macros for the barometric compensation block
// used by the port checker; needs nothing else
`ifndef BARO_TEMP_PRESSURE_COMPENSATION_ASSERT_SVH
`define BARO_TEMP_PRESSURE_COMPENSATION_ASSERT_SVH

// condition must hold in the same cycle
`define BTPC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition must hold in the following cycle
`define BTPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/btpc_pkg.sv =====
// shared types and constants of the barometric compensation block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package btpc_pkg;

	// field widths
	localparam int RAW_W      = 24;
	localparam int COEF_W     = 16;
	localparam int DT_W       = 26;
	localparam int STATE_W    = 40;
	localparam int READ_W     = 18;
	localparam int STATUS_W   = 2;
	localparam int OUT_DATA_W = 24;
	localparam int IDX_W      = 3;

	// scaling shifts
	localparam int T_SHIFT     = 23;
	localparam int OFF_SHIFT   = 6;
	localparam int SENS_SHIFT  = 7;
	localparam int SCALE_SHIFT = 21;
	localparam int P_SHIFT     = 15;
	localparam int OFF_BASE_SH  = 17;
	localparam int SENS_BASE_SH = 16;
	localparam int TREF_SH      = 8;

	// derived datapath widths
	localparam int PT_W   = DT_W + COEF_W + 1;
	localparam int TEMP_W = PT_W - T_SHIFT;
	localparam int HALF_W = RAW_W / 2;
	localparam int PART_W = HALF_W + 1 + STATE_W;
	localparam int PROD_W = 60;
	localparam int DIFF_W = STATE_W + 1;
	localparam int PRES_W = DIFF_W - P_SHIFT;

	// limits
	localparam logic signed [TEMP_W-1:0] TEMP_BASE = 20'sd2000;
	localparam logic signed [TEMP_W-1:0] TEMP_MIN  = -20'sd4000;
	localparam logic signed [TEMP_W-1:0] TEMP_MAX  = 20'sd8500;
	localparam logic signed [PRES_W-1:0] PRES_MIN  = 26'sd1000;
	localparam logic signed [PRES_W-1:0] PRES_MAX  = 26'sd120000;

	// register indexes
	localparam logic [IDX_W-1:0] REG_SENS      = 3'd0;
	localparam logic [IDX_W-1:0] REG_OFFSET    = 3'd1;
	localparam logic [IDX_W-1:0] REG_SENS_TC   = 3'd2;
	localparam logic [IDX_W-1:0] REG_OFFSET_TC = 3'd3;
	localparam logic [IDX_W-1:0] REG_TREF      = 3'd4;
	localparam logic [IDX_W-1:0] REG_TSENS     = 3'd5;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOTEMP = 2'd2;

	// calibration words
	typedef struct packed {
		logic [COEF_W-1:0] sens;
		logic [COEF_W-1:0] offset;
		logic [COEF_W-1:0] sens_tc;
		logic [COEF_W-1:0] offset_tc;
		logic [COEF_W-1:0] tref;
		logic [COEF_W-1:0] tsens;
	} coef_t;

	// item handed from the front end to the pressure back end
	typedef struct packed {
		logic                       done;
		logic [READ_W-1:0]          reading;
		logic [STATUS_W-1:0]        status;
		logic signed [PART_W-1:0]   part_lo;
		logic signed [PART_W-1:0]   part_hi;
		logic signed [STATE_W-1:0]  off;
	} mid_t;

endpackage

`default_nettype wire

// ===== hdl/btpc_cfg.sv =====
// calibration register file of the barometric compensation block
// depends on btpc_pkg
`timescale 1ns / 1ps
`default_nettype none

module btpc_cfg import btpc_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [IDX_W-1:0]  cfg_index,
	input  wire logic [COEF_W-1:0] cfg_data,
	output coef_t                  coef
);

	coef_t coef_q;

	// always able to take a word
	assign cfg_ready = 1'b1;

	// register writes, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_SENS:      coef_q.sens      <= cfg_data;
				REG_OFFSET:    coef_q.offset    <= cfg_data;
				REG_SENS_TC:   coef_q.sens_tc   <= cfg_data;
				REG_OFFSET_TC: coef_q.offset_tc <= cfg_data;
				REG_TREF:      coef_q.tref      <= cfg_data;
				REG_TSENS:     coef_q.tsens     <= cfg_data;
				default: ;
			endcase
		end
	end

	assign coef = coef_q;

endmodule

`default_nettype wire

// ===== hdl/btpc_front.sv =====
// front end: input stage, temperature products, compensation state
// and the split pressure multiply; depends on btpc_pkg
`timescale 1ns / 1ps
`default_nettype none

module btpc_front import btpc_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire coef_t            coef,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic             in_mode,
	input  wire logic [RAW_W-1:0] in_raw,
	output logic                  mid_valid,
	input  wire logic             mid_ready,
	output mid_t                  mid
);

	logic                      v_s1, v_s2;
	logic                      rdy_s1, rdy_s2;
	logic                      mode_s1, mode_s2;
	logic [RAW_W-1:0]          raw_s1, raw_s2;
	logic signed [DT_W-1:0]    dt_in, dt_s1;
	logic signed [PT_W-1:0]    dt_wide;
	logic signed [PT_W-1:0]    pt_s2, po_s2, ps_s2;
	logic signed [STATE_W-1:0] off_q, sens_q;
	logic signed [PART_W-1:0]  sens_wide;
	logic                      have_temp_q;

	logic                      t_corr, o_corr, s_corr;
	logic signed [TEMP_W-1:0]  tq, temp_val;
	logic                      t_ok, commit;
	logic signed [STATE_W-1:0] off_new, sens_new;
	logic signed [PART_W-1:0]  part_lo, part_hi;

	// handshake between stages
	assign rdy_s2    = !v_s2 || mid_ready;
	assign rdy_s1    = !v_s1 || rdy_s2;
	assign in_ready  = rdy_s1;
	assign mid_valid = v_s2;

	// dt straight from the incoming word
	assign dt_in = $signed({2'b00, in_raw}) - $signed({2'b00, coef.tref, {TREF_SH{1'b0}}});

	// dt widened to the product width
	assign dt_wide = $signed({{(PT_W-DT_W){dt_s1[DT_W-1]}}, dt_s1});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
		end
	end

	// input register and temperature products
	always_ff @(posedge clk) begin
		if (in_valid && rdy_s1) begin
			mode_s1 <= in_mode;
			raw_s1  <= in_raw;
			dt_s1   <= dt_in;
		end
		if (v_s1 && rdy_s2) begin
			mode_s2 <= mode_s1;
			raw_s2  <= raw_s1;
			pt_s2   <= dt_wide * $signed({{(PT_W-COEF_W){1'b0}}, coef.tsens});
			po_s2   <= dt_wide * $signed({{(PT_W-COEF_W){1'b0}}, coef.offset_tc});
			ps_s2   <= dt_wide * $signed({{(PT_W-COEF_W){1'b0}}, coef.sens_tc});
		end
	end

	// temperature, rounded toward zero
	assign t_corr   = pt_s2[PT_W-1] && (|pt_s2[T_SHIFT-1:0]);
	assign tq       = pt_s2[PT_W-1:T_SHIFT];
	assign temp_val = tq + TEMP_BASE + $signed({{(TEMP_W-1){1'b0}}, t_corr});
	assign t_ok     = (temp_val >= TEMP_MIN) && (temp_val <= TEMP_MAX);

	// offset and sensitivity for the current temperature
	assign o_corr  = po_s2[PT_W-1] && (|po_s2[OFF_SHIFT-1:0]);
	assign s_corr  = ps_s2[PT_W-1] && (|ps_s2[SENS_SHIFT-1:0]);
	assign off_new = $signed({{(STATE_W-COEF_W-OFF_BASE_SH){1'b0}}, coef.offset,
			{OFF_BASE_SH{1'b0}}})
		+ $signed({{(STATE_W-PT_W+OFF_SHIFT){po_s2[PT_W-1]}}, po_s2[PT_W-1:OFF_SHIFT]})
		+ $signed({{(STATE_W-1){1'b0}}, o_corr});
	assign sens_new = $signed({{(STATE_W-COEF_W-SENS_BASE_SH){1'b0}}, coef.sens,
			{SENS_BASE_SH{1'b0}}})
		+ $signed({{(STATE_W-PT_W+SENS_SHIFT){ps_s2[PT_W-1]}}, ps_s2[PT_W-1:SENS_SHIFT]})
		+ $signed({{(STATE_W-1){1'b0}}, s_corr});

	// state taken over as an in-range temperature word leaves the stage
	assign commit = v_s2 && mid_ready && !mode_s2 && t_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_temp_q <= 1'b0;
			off_q       <= '0;
			sens_q      <= '0;
		end else if (commit) begin
			have_temp_q <= 1'b1;
			off_q       <= off_new;
			sens_q      <= sens_new;
		end
	end

	// raw times sensitivity as two half-width partial products
	assign sens_wide = $signed({{(PART_W-STATE_W){sens_q[STATE_W-1]}}, sens_q});
	assign part_lo   = $signed({{(PART_W-HALF_W){1'b0}}, raw_s2[HALF_W-1:0]}) * sens_wide;
	assign part_hi   = $signed({{(PART_W-HALF_W){1'b0}}, raw_s2[RAW_W-1:HALF_W]}) * sens_wide;

	// word for the back end
	always_comb begin
		mid         = '0;
		mid.part_lo = part_lo;
		mid.part_hi = part_hi;
		mid.off     = off_q;
		if (!mode_s2) begin
			mid.done = 1'b1;
			if (t_ok) begin
				mid.reading = temp_val[READ_W-1:0];
				mid.status  = ST_OK;
			end else begin
				mid.status  = ST_RANGE;
			end
		end else if (!have_temp_q) begin
			mid.done   = 1'b1;
			mid.status = ST_NOTEMP;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/btpc_back.sv =====
// back end: partial product sum, offset removal, pressure range check
// and the result register; depends on btpc_pkg
`timescale 1ns / 1ps
`default_nettype none

module btpc_back import btpc_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 mid_valid,
	output logic                      mid_ready,
	input  wire mid_t                 mid,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [READ_W-1:0]         out_reading,
	output logic [STATUS_W-1:0]       out_status
);

	logic v_s3, v_s4, v_s5, v_s6;
	logic rdy_s3, rdy_s4, rdy_s5, rdy_s6;

	mid_t                      mid_s3;
	logic                      done_s4, done_s5;
	logic [READ_W-1:0]         reading_s4, reading_s5, reading_s6;
	logic [STATUS_W-1:0]       status_s4, status_s5, status_s6;
	logic signed [PROD_W-1:0]  prod, prod_s4;
	logic signed [STATE_W-1:0] off_s4;
	logic signed [DIFF_W-1:0]  diff, diff_s5;
	logic                      sc_corr, p_corr, p_ok;
	logic signed [PRES_W-1:0]  p_val;

	// handshake between stages
	assign rdy_s6    = !v_s6 || out_ready;
	assign rdy_s5    = !v_s5 || rdy_s6;
	assign rdy_s4    = !v_s4 || rdy_s5;
	assign rdy_s3    = !v_s3 || rdy_s4;
	assign mid_ready = rdy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (rdy_s3) v_s3 <= mid_valid;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_s5) v_s5 <= v_s4;
			if (rdy_s6) v_s6 <= v_s5;
		end
	end

	// full product from the two partials
	assign prod = $signed({mid_s3.part_hi[PROD_W-HALF_W-1:0], {HALF_W{1'b0}}})
		+ $signed({{(PROD_W-PART_W){mid_s3.part_lo[PART_W-1]}}, mid_s3.part_lo});

	// scaled product minus offset, rounding folded in as a carry
	assign sc_corr = prod_s4[PROD_W-1] && (|prod_s4[SCALE_SHIFT-1:0]);
	assign diff = $signed({{(DIFF_W-PROD_W+SCALE_SHIFT){prod_s4[PROD_W-1]}},
			prod_s4[PROD_W-1:SCALE_SHIFT]})
		- $signed({off_s4[STATE_W-1], off_s4})
		+ $signed({{(DIFF_W-1){1'b0}}, sc_corr});

	// pressure and its range check
	assign p_corr = diff_s5[DIFF_W-1] && (|diff_s5[P_SHIFT-1:0]);
	assign p_val  = $signed(diff_s5[DIFF_W-1:P_SHIFT]) + $signed({{(PRES_W-1){1'b0}}, p_corr});
	assign p_ok   = (p_val >= PRES_MIN) && (p_val <= PRES_MAX);

	always_ff @(posedge clk) begin
		if (mid_valid && rdy_s3) begin
			mid_s3 <= mid;
		end
		if (v_s3 && rdy_s4) begin
			done_s4    <= mid_s3.done;
			reading_s4 <= mid_s3.reading;
			status_s4  <= mid_s3.status;
			prod_s4    <= prod;
			off_s4     <= mid_s3.off;
		end
		if (v_s4 && rdy_s5) begin
			done_s5    <= done_s4;
			reading_s5 <= reading_s4;
			status_s5  <= status_s4;
			diff_s5    <= diff;
		end
		if (v_s5 && rdy_s6) begin
			if (done_s5) begin
				reading_s6 <= reading_s5;
				status_s6  <= status_s5;
			end else if (p_ok) begin
				reading_s6 <= p_val[READ_W-1:0];
				status_s6  <= ST_OK;
			end else begin
				reading_s6 <= '0;
				status_s6  <= ST_RANGE;
			end
		end
	end

	assign out_valid   = v_s6;
	assign out_reading = reading_s6;
	assign out_status  = status_s6;

endmodule

`default_nettype wire

// ===== hdl/baro_temp_pressure_compensation.sv =====
// Barometric sensor compensation, first-order temperature and pressure.
// Input words on s_*: tdata carries the 24-bit raw conversion, tuser says
// whether it is a temperature (0) or a pressure (1) conversion.
// Each input word gives exactly one result word on m_*: tdata holds the
// signed 18-bit reading (0.01 C or 0.01 mbar), tuser the status
// (0 ok, 1 out of range, 2 no valid temperature yet); reading is 0 unless ok.
// Calibration words C1..C6 are written on cfg_* (index 0..5, others dropped);
// write them only while no word is in flight.
// Pipeline: six register stages; the pressure multiply is split into two
// half-width partial products, which the back end sums and then scales.
// Throughput: one word per cycle unless m_tready stalls; a pressure word may
// directly follow the temperature word it depends on, the stored offset and
// sensitivity are updated as an in-range temperature word leaves stage two.
// Reset clears the calibration words, the pipeline and the valid
// temperature flag. When m_tready is low the result register holds, bubbles
// ahead of it still fill, and s_tready falls once all six stages are full.
// Depends on btpc_pkg, btpc_cfg, btpc_front and btpc_back.
`timescale 1ns / 1ps
`default_nettype none

module baro_temp_pressure_compensation import btpc_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [RAW_W-1:0]      s_tdata,   // [23:0] raw_sample
	input  wire logic [0:0]            s_tuser,   // [0] mode
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [OUT_DATA_W-1:0]      m_tdata,   // [17:0] reading, [23:18] zero
	output logic [STATUS_W-1:0]        m_tuser,   // [1:0] status
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [IDX_W-1:0]      cfg_index,
	input  wire logic [COEF_W-1:0]     cfg_data
);

	coef_t             coef;
	mid_t              mid;
	logic              mid_valid, mid_ready;
	logic [READ_W-1:0] reading;

	// calibration registers
	btpc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.coef      (coef)
	);

	// temperature path and stored compensation
	btpc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.coef      (coef),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_mode   (s_tuser[0]),
		.in_raw    (s_tdata),
		.mid_valid (mid_valid),
		.mid_ready (mid_ready),
		.mid       (mid)
	);

	// pressure path and result register
	btpc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.mid_valid   (mid_valid),
		.mid_ready   (mid_ready),
		.mid         (mid),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_reading (reading),
		.out_status  (m_tuser)
	);

	// pack the result word
	assign m_tdata = {{(OUT_DATA_W-READ_W){1'b0}}, reading};

endmodule

`default_nettype wire

// ===== hdl/btpc_checker.sv =====
// port checker for the barometric compensation block, bound to the top level
// depends on btpc_pkg and baro_temp_pressure_compensation_assert.svh
`timescale 1ns / 1ps
`default_nettype none

`include "baro_temp_pressure_compensation_assert.svh"

module btpc_checker import btpc_pkg::*; (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  m_tvalid,
	input wire logic                  m_tready,
	input wire logic [OUT_DATA_W-1:0] m_tdata,
	input wire logic [STATUS_W-1:0]   m_tuser
);

	// stalled result word holds
	`BTPC_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result word changed while stalled")

	// a failed result carries a zero reading
	`BTPC_ASSERT_NOW(a_fail_zero, clk, arst_n, m_tvalid && (m_tuser != ST_OK), m_tdata == '0, "nonzero reading with failure status")

	// a good reading lies inside the temperature and pressure span
	`BTPC_ASSERT_NOW(a_ok_span, clk, arst_n, m_tvalid && (m_tuser == ST_OK), ($signed(m_tdata[READ_W-1:0]) >= $signed(TEMP_MIN[READ_W-1:0])) && ($signed(m_tdata[READ_W-1:0]) <= $signed(PRES_MAX[READ_W-1:0])), "good reading outside its span")

	// padding above the reading stays clear
	`BTPC_ASSERT_NOW(a_pad_zero, clk, arst_n, m_tvalid, m_tdata[OUT_DATA_W-1:READ_W] == '0, "padding bits set in result word")

endmodule

bind baro_temp_pressure_compensation btpc_checker u_btpc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata),
	.m_tuser   (m_tuser)
);

`default_nettype wire
